FILE: hw/rtl/integer_to_ascii_formatter_macros.svh
// Assertion macros used by the formatter's datapath (i2a_dp).
// They expect a clock named clk and an active-low reset named arst_n in scope.
`ifndef INTEGER_TO_ASCII_FORMATTER_MACROS_SVH
`define INTEGER_TO_ASCII_FORMATTER_MACROS_SVH

// Same-cycle implication.
`define I2A_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define I2A_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/i2a_pkg.sv
`default_nettype none
package i2a_pkg;

	localparam int unsigned ValueW       = 64;
	localparam int unsigned LowW         = 32;
	localparam int unsigned ActionW      = 3;
	localparam int unsigned CharW        = 7;
	localparam int unsigned DigitW       = 4;
	localparam int unsigned NumDigits    = 16;
	localparam int unsigned DecDigits    = 10;
	localparam int unsigned HexLowDigits = 8;
	localparam int unsigned CntW         = 5;
	localparam int unsigned ConvSteps    = 32;
	localparam int unsigned StepW        = 5;
	localparam int unsigned PrefixIdxW   = 3;

	localparam logic [ActionW-1:0] ActSdec = 3'd0;
	localparam logic [ActionW-1:0] ActUdec = 3'd1;
	localparam logic [ActionW-1:0] ActHexl = 3'd2;
	localparam logic [ActionW-1:0] ActHexu = 3'd3;
	localparam logic [ActionW-1:0] ActPtr  = 3'd4;

	localparam logic [CharW-1:0] ChZero   = 7'h30;
	localparam logic [CharW-1:0] ChLowerA = 7'h61;
	localparam logic [CharW-1:0] ChUpperA = 7'h41;
	localparam logic [CharW-1:0] ChMinus  = 7'h2d;
	localparam logic [CharW-1:0] ChX      = 7'h78;
	localparam logic [CharW-1:0] ChOpen   = 7'h28;
	localparam logic [CharW-1:0] ChN      = 7'h6e;
	localparam logic [CharW-1:0] ChI      = 7'h69;
	localparam logic [CharW-1:0] ChL      = 7'h6c;
	localparam logic [CharW-1:0] ChClose  = 7'h29;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_TRIM,
		ST_PREFIX,
		ST_DIGITS
	} state_t;

	typedef enum logic [1:0] {
		PFX_NONE,
		PFX_MINUS,
		PFX_HEX,
		PFX_NIL
	} pfx_t;

	typedef struct packed {
		logic load;
		logic conv_step;
		logic trim_step;
		logic emit_prefix;
		logic emit_digit;
	} cmd_t;

	typedef struct packed {
		logic act_ok;
		logic is_dec;
		logic conv_done;
		logic trim_done;
		logic has_prefix;
		logic prefix_last;
		logic no_digits;
		logic digit_last;
		logic slot_free;
	} sts_t;

	function automatic logic [CharW-1:0] digit_char(input logic [DigitW-1:0] d,
		input logic upper);
		logic [CharW-1:0] dx;
		dx = {{(CharW-DigitW){1'b0}}, d};
		if (d < 4'd10) begin
			return ChZero + dx;
		end else if (upper) begin
			return ChUpperA + dx - 7'd10;
		end else begin
			return ChLowerA + dx - 7'd10;
		end
	endfunction

	function automatic logic [CharW-1:0] prefix_char(input pfx_t kind,
		input logic [PrefixIdxW-1:0] idx);
		logic [CharW-1:0] ch;
		ch = ChZero;
		unique case (kind)
			PFX_MINUS: ch = ChMinus;
			PFX_HEX: ch = (idx == 3'd0) ? ChZero : ChX;
			PFX_NIL: begin
				priority case (idx)
					3'd0: ch = ChOpen;
					3'd1: ch = ChN;
					3'd2: ch = ChI;
					3'd3: ch = ChL;
					default: ch = ChClose;
				endcase
			end
			PFX_NONE: ch = ChZero;
		endcase
		return ch;
	endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/i2a_if.sv
`default_nettype none
interface i2a_in_if;
	logic        valid;
	logic        ready;
	logic [2:0]  action;
	logic [63:0] value;

	modport source (output valid, output action, output value, input ready);
	modport sink (input valid, input action, input value, output ready);
endinterface

interface i2a_out_if;
	logic       valid;
	logic       ready;
	logic [6:0] character;
	logic       last;

	modport source (output valid, output character, output last, input ready);
	modport sink (input valid, input character, input last, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/i2a_ctrl.sv
`default_nettype none
module i2a_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire i2a_pkg::sts_t sts,
	output i2a_pkg::cmd_t      cmd
);
	import i2a_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid && sts.act_ok) begin
					cmd.load = 1'b1;
					state_d  = sts.is_dec ? ST_CONV : ST_TRIM;
				end
			end
			ST_CONV: begin
				cmd.conv_step = 1'b1;
				if (sts.conv_done) begin
					state_d = ST_TRIM;
				end
			end
			ST_TRIM: begin
				if (!sts.trim_done) begin
					cmd.trim_step = 1'b1;
				end else if (sts.has_prefix) begin
					state_d = ST_PREFIX;
				end else begin
					state_d = ST_DIGITS;
				end
			end
			ST_PREFIX: begin
				if (sts.slot_free) begin
					cmd.emit_prefix = 1'b1;
					if (sts.prefix_last) begin
						state_d = sts.no_digits ? ST_IDLE : ST_DIGITS;
					end
				end
			end
			ST_DIGITS: begin
				if (sts.slot_free) begin
					cmd.emit_digit = 1'b1;
					if (sts.digit_last) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule
`default_nettype wire

FILE: hw/rtl/i2a_dp.sv
`default_nettype none
`include "integer_to_ascii_formatter_macros.svh"
module i2a_dp (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic [2:0]    action,
	input  wire logic [63:0]   value,
	input  wire i2a_pkg::cmd_t cmd,
	output i2a_pkg::sts_t      sts,
	i2a_out_if.source          text
);
	import i2a_pkg::*;

	logic [NumDigits-1:0][DigitW-1:0] buf_q;
	logic [LowW-1:0]                  bin_q;
	logic [CntW-1:0]                  cnt_q;
	logic [StepW-1:0]                 step_q;
	logic [PrefixIdxW-1:0]            pidx_q;
	pfx_t                             pfx_q;
	logic                             upper_q;
	logic [CharW-1:0]                 char_q;
	logic                             last_q;
	logic                             ovalid_q;

	logic [LowW-1:0]                  low;
	logic                             neg;
	logic [LowW-1:0]                  mag;
	logic [CntW-1:0]                  cnt_m1;
	logic [DigitW-1:0]                nib;
	logic [DecDigits-1:0][DigitW-1:0] adj;
	logic [DecDigits*DigitW-1:0]      dd_bcd;
	logic [LowW-1:0]                  dd_bin;
	logic                             pfx_last;
	logic                             slot_free;

	assign low    = value[LowW-1:0];
	assign neg    = (action == ActSdec) && low[LowW-1];
	assign mag    = neg ? (~low + LowW'(1)) : low;
	assign cnt_m1 = cnt_q - CntW'(1);
	assign nib    = buf_q[cnt_m1[3:0]];

	always_comb begin
		for (int i = 0; i < DecDigits; i++) begin
			adj[i] = (buf_q[i] >= 4'd5) ? buf_q[i] + 4'd3 : buf_q[i];
		end
		{dd_bcd, dd_bin} = {adj, bin_q} << 1;
	end

	always_comb begin
		pfx_last = 1'b1;
		unique case (pfx_q)
			PFX_MINUS: pfx_last = (pidx_q == 3'd0);
			PFX_HEX: pfx_last = (pidx_q == 3'd1);
			PFX_NIL: pfx_last = (pidx_q == 3'd4);
			PFX_NONE: pfx_last = 1'b1;
		endcase
	end

	assign slot_free = !ovalid_q || text.ready;

	always_comb begin
		sts.act_ok      = (action <= ActPtr);
		sts.is_dec      = (action == ActSdec) || (action == ActUdec);
		sts.conv_done   = (step_q == StepW'(ConvSteps - 1));
		sts.trim_done   = (cnt_q <= CntW'(1)) || (nib != '0);
		sts.has_prefix  = (pfx_q != PFX_NONE);
		sts.prefix_last = pfx_last;
		sts.no_digits   = (cnt_q == '0);
		sts.digit_last  = (cnt_q == CntW'(1));
		sts.slot_free   = slot_free;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			step_q  <= '0;
			pidx_q  <= '0;
			upper_q <= (action == ActHexu);
			priority if ((action == ActSdec) || (action == ActUdec)) begin
				bin_q <= mag;
				buf_q <= '0;
				cnt_q <= CntW'(DecDigits);
				pfx_q <= neg ? PFX_MINUS : PFX_NONE;
			end else if ((action == ActHexl) || (action == ActHexu)) begin
				buf_q <= {{(ValueW-LowW){1'b0}}, low};
				cnt_q <= CntW'(HexLowDigits);
				pfx_q <= PFX_NONE;
			end else begin
				buf_q <= value;
				cnt_q <= (value == '0) ? '0 : CntW'(NumDigits);
				pfx_q <= (value == '0) ? PFX_NIL : PFX_HEX;
			end
		end else begin
			if (cmd.conv_step) begin
				buf_q[DecDigits-1:0] <= dd_bcd;
				bin_q                <= dd_bin;
				step_q               <= step_q + StepW'(1);
			end
			if (cmd.trim_step || cmd.emit_digit) begin
				cnt_q <= cnt_m1;
			end
			if (cmd.emit_prefix) begin
				pidx_q <= pidx_q + PrefixIdxW'(1);
			end
		end
		if (cmd.emit_prefix) begin
			char_q <= prefix_char(pfx_q, pidx_q);
			last_q <= (pfx_q == PFX_NIL) && pfx_last;
		end else if (cmd.emit_digit) begin
			char_q <= digit_char(nib, upper_q);
			last_q <= (cnt_q == CntW'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (cmd.emit_prefix || cmd.emit_digit) begin
			ovalid_q <= 1'b1;
		end else if (text.ready) begin
			ovalid_q <= 1'b0;
		end
	end

	assign text.valid     = ovalid_q;
	assign text.character = char_q;
	assign text.last      = last_q;

	`I2A_ASSERT_IMP(a_emit_needs_slot, cmd.emit_prefix || cmd.emit_digit, slot_free, "emit while output register is occupied")
	`I2A_ASSERT_IMP(a_digit_count_nonzero, cmd.emit_digit, cnt_q != '0, "digit emitted with no digits left")
	`I2A_ASSERT_IMP(a_bcd_upper_clear, cmd.conv_step, buf_q[NumDigits-1:DecDigits] == '0, "upper digits not clear during decimal conversion")
	`I2A_ASSERT_NEXT(a_quiet_after_last, cmd.emit_digit && (cnt_q == CntW'(1)), !cmd.emit_digit && !cmd.emit_prefix, "character emitted after the last one")

endmodule
`default_nettype wire

FILE: hw/rtl/integer_to_ascii_formatter.sv
`default_nettype none
// Prints one number per input transfer as ASCII text, one character per output transfer,
// most significant character first, with last set on the final character. Formats are
// signed or unsigned 32-bit decimal, 32-bit hex in lower or upper case, and a 64-bit
// pointer form ("0x" plus lower-case hex, or "(nil)" for zero); selector codes 5 to 7
// are taken and produce no output. One number is handled at a time: after the input
// transfer, decimal formats run the bit-serial binary-to-BCD loop, then every format
// drops one leading zero digit per cycle (up to 9 for decimal, 7 for hex, 15 for
// pointer), then moves on to the prefix or digit phase, and finally sends one
// character per cycle while the output is ready. Every dropped zero is one character
// fewer. The last character sits in an output register, so the next number is taken
// while it still waits for its transfer.
module integer_to_ascii_formatter (
	input wire logic  clk,
	input wire logic  arst_n,
	i2a_in_if.sink    number,
	i2a_out_if.source text
);
	import i2a_pkg::*;

	cmd_t cmd;
	sts_t sts;
	logic in_ready;

	i2a_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (number.valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	i2a_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.action (number.action),
		.value  (number.value),
		.cmd    (cmd),
		.sts    (sts),
		.text   (text)
	);

	assign number.ready = in_ready;

endmodule
`default_nettype wire

FILE: sim/integer_to_ascii_formatter_tb.sv
`timescale 1ns / 100ps

module integer_to_ascii_formatter_tb;
	import i2a_pkg::*;

	typedef struct packed {
		logic [ActionW-1:0] action;
		logic [ValueW-1:0]  value;
	} number_t;

	typedef struct packed {
		logic [CharW-1:0] character;
		logic             last;
	} glyph_t;

	localparam int unsigned RandomNumbers = 150;
	localparam int unsigned StallLimit    = 2000;
	localparam int unsigned DrainCycles   = 80;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic               in_valid = 1'b0;
	logic [ActionW-1:0] in_action = '0;
	logic [ValueW-1:0]  in_value = '0;
	logic               out_ready = 1'b0;

	number_t pending_numbers[$];
	glyph_t  pending_glyphs[$];

	int unsigned burst_left = 1;
	int unsigned gap_left = 0;
	int unsigned rx_mode = 0;
	int unsigned rx_mode_left = 0;
	int unsigned rx_phase = 0;
	int unsigned idle_cycles = 0;
	int unsigned numbers_taken = 0;
	int unsigned ignored_taken = 0;
	int unsigned glyphs_seen = 0;
	int unsigned errors = 0;

	i2a_in_if  number_if ();
	i2a_out_if text_if ();

	assign number_if.valid  = in_valid;
	assign number_if.action = in_action;
	assign number_if.value  = in_value;
	assign text_if.ready    = out_ready;

	integer_to_ascii_formatter u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.number (number_if),
		.text   (text_if)
	);

	always #5 clk = ~clk;

	// Expands one number into the characters it should print and queues them.
	function automatic void spell_number(input logic [ActionW-1:0] fmt,
		input logic [ValueW-1:0] num);
		logic [CharW-1:0] chars[$];
		logic [CharW-1:0] alpha;
		logic [ValueW-1:0] mag;
		logic [ValueW-1:0] base;
		logic [LowW-1:0] neg;
		logic [DigitW-1:0] d;
		logic with_digits;
		int unsigned first_digit;
		alpha = ChLowerA;
		base = 64'd10;
		mag = {32'd0, num[LowW-1:0]};
		with_digits = 1'b1;
		case (fmt)
			ActSdec: begin
				if (num[LowW-1]) begin
					neg = ~num[LowW-1:0] + 32'd1;
					mag = {32'd0, neg};
					chars.push_back(ChMinus);
				end
			end
			ActUdec: begin
			end
			ActHexl: begin
				base = 64'd16;
			end
			ActHexu: begin
				base = 64'd16;
				alpha = ChUpperA;
			end
			ActPtr: begin
				base = 64'd16;
				mag = num;
				if (num == '0) begin
					with_digits = 1'b0;
					chars.push_back(ChOpen);
					chars.push_back(ChN);
					chars.push_back(ChI);
					chars.push_back(ChL);
					chars.push_back(ChClose);
				end else begin
					chars.push_back(ChZero);
					chars.push_back(ChX);
				end
			end
			default: return;
		endcase
		if (with_digits) begin
			first_digit = chars.size();
			do begin
				d = DigitW'(mag % base);
				if (d < 4'd10) begin
					chars.insert(first_digit, ChZero + CharW'(d));
				end else begin
					chars.insert(first_digit, alpha + CharW'(d) - 7'd10);
				end
				mag = mag / base;
			end while (mag != '0);
		end
		foreach (chars[i]) begin
			pending_glyphs.push_back('{character: chars[i], last: (i == chars.size() - 1)});
		end
	endfunction

	task automatic queue_number(input logic [ActionW-1:0] fmt, input logic [ValueW-1:0] num);
		pending_numbers.push_back('{action: fmt, value: num});
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_action <= '0;
			in_value <= '0;
			burst_left <= 1;
			gap_left <= 0;
		end else begin
			if (in_valid && number_if.ready) begin
				spell_number(in_action, in_value);
				if (in_action > ActPtr) begin
					ignored_taken <= ignored_taken + 1;
				end else begin
					numbers_taken <= numbers_taken + 1;
				end
			end
			if (!in_valid || number_if.ready) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					in_valid <= 1'b0;
				end else if (pending_numbers.size() > 0) begin
					number_t nxt;
					nxt = pending_numbers.pop_front();
					in_valid <= 1'b1;
					in_action <= nxt.action;
					in_value <= nxt.value;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 12);
						case ($urandom_range(0, 3))
							0: gap_left <= 0;
							1: gap_left <= $urandom_range(1, 3);
							2: gap_left <= $urandom_range(4, 20);
							default: gap_left <= $urandom_range(21, 60);
						endcase
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// The receiver switches between always ready, coin flips, mostly stalled and a
	// fixed one-in-three pattern.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			rx_mode <= 0;
			rx_mode_left <= 0;
			rx_phase <= 0;
		end else begin
			if (rx_mode_left == 0) begin
				rx_mode <= $urandom_range(0, 3);
				rx_mode_left <= $urandom_range(40, 250);
			end else begin
				rx_mode_left <= rx_mode_left - 1;
			end
			rx_phase <= (rx_phase == 2) ? 0 : rx_phase + 1;
			case (rx_mode)
				0: out_ready <= 1'b1;
				1: out_ready <= $urandom_range(0, 1) == 1;
				2: out_ready <= $urandom_range(0, 3) == 0;
				default: out_ready <= rx_phase == 0;
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && text_if.valid && out_ready) begin
			glyphs_seen <= glyphs_seen + 1;
			if (pending_glyphs.size() == 0) begin
				$display("%0t: unexpected character, expected none, actual %h last %b",
					$time, text_if.character, text_if.last);
				errors <= errors + 1;
			end else begin
				glyph_t want;
				want = pending_glyphs.pop_front();
				if (text_if.character !== want.character) begin
					$display("%0t: character mismatch, expected %h, actual %h",
						$time, want.character, text_if.character);
				end
				if (text_if.last !== want.last) begin
					$display("%0t: last mismatch, expected %b, actual %b",
						$time, want.last, text_if.last);
				end
				if ((text_if.character !== want.character) || (text_if.last !== want.last)) begin
					errors <= errors + 1;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && number_if.ready) || (text_if.valid && out_ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles + 1 >= StallLimit) begin
				$display("%0t: no transfer for %0d cycles", $time, StallLimit);
				$display("tb: failure");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		int unsigned counted;
		int unsigned shift;
		logic [ActionW-1:0] fmt;
		logic [ValueW-1:0] raw;
		logic [ValueW-1:0] num;

		queue_number(ActSdec, 64'd0);
		queue_number(ActSdec, 64'd9);
		queue_number(ActSdec, 64'hFFFF_0000_7FFF_FFFF);
		queue_number(ActSdec, 64'h0000_0000_8000_0000);
		queue_number(ActSdec, 64'h1234_5678_FFFF_FFFF);
		queue_number(ActSdec, 64'h0000_0000_FFFF_FFF6);
		queue_number(ActUdec, 64'd0);
		queue_number(ActUdec, 64'd10);
		queue_number(ActUdec, 64'hFFFF_FFFF_FFFF_FFFF);
		queue_number(ActUdec, 64'h0000_0001_3B9A_CA00);
		queue_number(ActHexl, 64'hFFFF_FFFF_0000_0000);
		queue_number(ActHexl, 64'h0000_0000_ABCD_EF09);
		queue_number(ActHexl, 64'h0000_0000_FFFF_FFFF);
		queue_number(ActHexu, 64'h5555_5555_0A1B_2C3D);
		queue_number(ActHexu, 64'h0000_0000_FFFF_FFFF);
		queue_number(ActHexu, 64'd15);
		queue_number(ActPtr, 64'd0);
		queue_number(ActPtr, 64'd1);
		queue_number(ActPtr, 64'hFFFF_FFFF_FFFF_FFFF);
		queue_number(ActPtr, 64'h0000_0001_0000_0000);
		queue_number(ActPtr, 64'hABCD_EF01_2345_6789);
		queue_number(3'd5, 64'd123);
		queue_number(3'd6, 64'hFFFF_FFFF_FFFF_FFFF);
		queue_number(3'd7, 64'd0);

		counted = 0;
		while (counted < RandomNumbers) begin
			if ($urandom_range(0, 99) < 5) begin
				fmt = ActionW'($urandom_range(5, 7));
			end else begin
				fmt = ActionW'($urandom_range(0, 4));
				counted++;
			end
			raw = {$urandom, $urandom};
			shift = $urandom_range(0, 63);
			case ($urandom_range(0, 3))
				0: num = raw;
				1: num = raw >> shift;
				2: num = {raw[63:32], raw[31:0] >> shift[4:0]};
				default: num = {($urandom_range(0, 1) == 1) ? raw[63:32] : 32'd0, 32'd0};
			endcase
			queue_number(fmt, num);
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_numbers.size() > 0 || in_valid) begin
			@(posedge clk);
		end
		while (pending_glyphs.size() > 0) begin
			@(posedge clk);
		end
		repeat (DrainCycles) @(posedge clk);

		$display("Printed %0d numbers in all five formats as %0d characters,",
			numbers_taken, glyphs_seen);
		$display("and dropped %0d items with unused selectors.", ignored_taken);
		if (errors == 0 && pending_glyphs.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
